/* hw/rtl/crp_pkg.sv */
package crp_pkg;

    // Fixed field widths of the request, result and configuration beats.
    localparam int PAGE_W      = 8;
    localparam int FRAME_OUT_W = 6;
    localparam int CNT_W       = 32;
    localparam int CFG_W       = 7;

    // Frame count after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Sequencer state codes.
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [ST_W-1:0] ST_SCAN   = 2'd1;
    localparam logic [ST_W-1:0] ST_SWEEP  = 2'd2;
    localparam logic [ST_W-1:0] ST_UPDATE = 2'd3;

    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [CNT_W-1:0]  count_t;

endpackage

/* hw/rtl/crp_page_mem.sv */
module crp_page_mem
    import crp_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  page_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output page_t         rd_data
);

    page_t mem [DEPTH];
    page_t rd_data_reg;

    // Page number of each frame: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/clock_page_replacement.sv */
// Channel  | Direction | Ports                                   | Carries
// s_       | in        | s_valid, s_ready, s_page_id             | one page request
// m_       | out       | m_valid, m_ready, m_was_hit, m_frame_index,
//          |           | m_hit_total, m_fault_total              | one result per request
// cfg_     | in        | cfg_valid, cfg_ready, cfg_data          | frames_in_use write
//
// A request is looked up one frame per cycle through the page memory's single
// read port; a fault that finds no empty frame then sweeps the clock hand, at
// most n + 1 steps. Reset is synchronous and active low; the frame valid and
// reference bits clear at once, page entries are left unwritten.
// Results sit in an output register, so the next request is taken while one
// is waiting; the update stalls only when a second result would overwrite it.
module clock_page_replacement
    import crp_pkg::*;
#(
    parameter int FRAME_SLOTS = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PAGE_W-1:0]      s_page_id,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_was_hit,
    output logic [FRAME_OUT_W-1:0] m_frame_index,
    output logic [CNT_W-1:0]       m_hit_total,
    output logic [CNT_W-1:0]       m_fault_total,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int IW = $clog2(FRAME_SLOTS);
    localparam int NW = $clog2(FRAME_SLOTS + 1);

    // Control state.
    logic [ST_W-1:0]        state_reg, state_next;
    logic [CFG_W-1:0]       frames_reg, frames_next;
    logic [FRAME_SLOTS-1:0] valid_reg, valid_next;
    logic [FRAME_SLOTS-1:0] ref_reg, ref_next;
    logic [IW-1:0]          hand_reg, hand_next;
    count_t                 hits_reg, hits_next;
    count_t                 faults_reg, faults_next;
    logic                   m_valid_reg, m_valid_next;
    logic [NW-1:0]          scan_reg, scan_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic                   cmp_last_reg, cmp_last_next;
    logic                   free_found_reg, free_found_next;

    // Payload state.
    page_t                  page_reg, page_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [IW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]          free_idx_reg, free_idx_next;
    logic [IW-1:0]          frame_reg, frame_next;
    logic                   hit_reg, hit_next;
    logic                   out_hit_reg, out_hit_next;
    logic [IW-1:0]          out_frame_reg, out_frame_next;
    count_t                 out_hits_reg, out_hits_next;
    count_t                 out_faults_reg, out_faults_next;

    logic                   mem_wr_en;
    page_t                  mem_rd_data;
    logic [IW-1:0]          scan_idx;
    logic [31:0]            cfg_ext;
    logic [NW-1:0]          n_eff;
    logic [NW-1:0]          hand_ext;
    logic [NW-1:0]          hand_inc;
    logic                   cmp_hit;
    logic                   free_now;
    logic [IW-1:0]          free_sel;
    logic                   out_free;

    assign scan_idx = scan_reg[IW-1:0];

    crp_page_mem #(
        .DEPTH (FRAME_SLOTS)
    ) u_page_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (frame_reg),
        .wr_data (page_reg),
        .rd_addr (scan_idx),
        .rd_data (mem_rd_data)
    );

    // Effective frame count: zero acts as one, anything above the slots is clipped.
    always_comb begin
        cfg_ext = 32'(frames_reg);
        if (cfg_ext == 32'd0) begin
            n_eff = NW'(1);
        end else if (cfg_ext > 32'(FRAME_SLOTS)) begin
            n_eff = NW'(FRAME_SLOTS);
        end else begin
            n_eff = NW'(frames_reg);
        end
    end

    // Compare of the page from the registered read, and the empty-frame candidate.
    assign cmp_hit  = cmp_vld_reg && valid_reg[cmp_idx_reg] && (mem_rd_data == page_reg);
    assign free_now = free_found_reg || !valid_reg[cmp_idx_reg];
    assign free_sel = free_found_reg ? free_idx_reg : cmp_idx_reg;

    assign hand_ext = NW'(hand_reg);
    assign hand_inc = hand_ext + NW'(1);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign mem_wr_en = (state_reg == ST_UPDATE) && out_free && !hit_reg;

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        frames_next     = frames_reg;
        valid_next      = valid_reg;
        ref_next        = ref_reg;
        hand_next       = hand_reg;
        hits_next       = hits_reg;
        faults_next     = faults_reg;
        m_valid_next    = m_valid_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = 1'b0;
        cmp_last_next   = cmp_last_reg;
        free_found_next = free_found_reg;
        page_next       = page_reg;
        n_next          = n_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_idx_next   = free_idx_reg;
        frame_next      = frame_reg;
        hit_next        = hit_reg;
        out_hit_next    = out_hit_reg;
        out_frame_next  = out_frame_reg;
        out_hits_next   = out_hits_reg;
        out_faults_next = out_faults_reg;

        if (cfg_valid && cfg_ready) begin
            frames_next = cfg_data;
        end

        // The waiting result leaves on its beat.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    page_next       = s_page_id;
                    n_next          = n_eff;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // Issue the next frame's read while frames remain.
                if (scan_reg < n_reg) begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx;
                    cmp_last_next = (scan_reg == n_reg - NW'(1));
                    scan_next     = scan_reg + NW'(1);
                end
                if (cmp_vld_reg) begin
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (cmp_hit) begin
                        hit_next     = 1'b1;
                        frame_next   = cmp_idx_reg;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_UPDATE;
                    end else if (cmp_last_reg) begin
                        hit_next = 1'b0;
                        if (free_now) begin
                            frame_next = free_sel;
                            state_next = ST_UPDATE;
                        end else begin
                            // A hand left beyond a shrunk frame count restarts at zero.
                            if (hand_ext >= n_reg) begin
                                hand_next = '0;
                            end
                            state_next = ST_SWEEP;
                        end
                    end
                end
            end

            ST_SWEEP: begin
                // One step of the clock hand per cycle.
                hand_next = (hand_inc == n_reg) ? '0 : IW'(hand_inc);
                if (!ref_reg[hand_reg]) begin
                    frame_next = hand_reg;
                    state_next = ST_UPDATE;
                end else begin
                    ref_next[hand_reg] = 1'b0;
                end
            end

            ST_UPDATE: begin
                if (out_free) begin
                    ref_next[frame_reg] = 1'b1;
                    if (hit_reg) begin
                        hits_next     = (&hits_reg) ? hits_reg : hits_reg + CNT_W'(1);
                        out_hits_next = hits_next;
                        out_faults_next = faults_reg;
                    end else begin
                        valid_next[frame_reg] = 1'b1;
                        faults_next     = (&faults_reg) ? faults_reg : faults_reg + CNT_W'(1);
                        out_faults_next = faults_next;
                        out_hits_next   = hits_reg;
                    end
                    out_hit_next   = hit_reg;
                    out_frame_next = frame_reg;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            frames_reg     <= CFG_RESET;
            valid_reg      <= '0;
            ref_reg        <= '0;
            hand_reg       <= '0;
            hits_reg       <= '0;
            faults_reg     <= '0;
            m_valid_reg    <= 1'b0;
            scan_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_last_reg   <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            frames_reg     <= frames_next;
            valid_reg      <= valid_next;
            ref_reg        <= ref_next;
            hand_reg       <= hand_next;
            hits_reg       <= hits_next;
            faults_reg     <= faults_next;
            m_valid_reg    <= m_valid_next;
            scan_reg       <= scan_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_last_reg   <= cmp_last_next;
            free_found_reg <= free_found_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        page_reg       <= page_next;
        n_reg          <= n_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_idx_reg   <= free_idx_next;
        frame_reg      <= frame_next;
        hit_reg        <= hit_next;
        out_hit_reg    <= out_hit_next;
        out_frame_reg  <= out_frame_next;
        out_hits_reg   <= out_hits_next;
        out_faults_reg <= out_faults_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_was_hit     = out_hit_reg;
    assign m_frame_index = FRAME_OUT_W'(out_frame_reg);
    assign m_hit_total   = out_hits_reg;
    assign m_fault_total = out_faults_reg;

endmodule
